// ===== hdl/gwcp_pkg.sv =====
// Package for the grid work chunk partitioner.
// Holds the fixed field widths, derived constants and the payload structs.
// No dependencies; every other file of the block imports it.
`default_nettype none

package gwcp_pkg;

  // Field widths and limits of the block.
  localparam int AXIS_BITS    = 16;
  localparam int MAX_WORKERS  = 16;
  localparam int RESULT_LIMIT = 63;
  localparam int WORKER_W     = 5;
  localparam int DIM_W        = 2;

  // Derived widths.
  localparam int PLANE_W = 2 * AXIS_BITS;
  localparam int TOT_W   = 3 * AXIS_BITS;
  localparam int CNT_W   = $clog2(TOT_W + 1);
  localparam int DIV2_W  = $clog2(2 * MAX_WORKERS + 1);
  localparam int RES_W   = $clog2(RESULT_LIMIT + 1);

  // Reset value of the worker count register.
  localparam logic [WORKER_W-1:0] WORKER_RESET = WORKER_W'(4);

  // Dimension codes.
  localparam logic [DIM_W-1:0] DIM_NONE = 2'd0;
  localparam logic [DIM_W-1:0] DIM_1D   = 2'd1;
  localparam logic [DIM_W-1:0] DIM_2D   = 2'd2;
  localparam logic [DIM_W-1:0] DIM_3D   = 2'd3;

  // One launch request.
  typedef struct packed {
    logic [DIM_W-1:0]     dim_count;
    logic [AXIS_BITS-1:0] x_lo;
    logic [AXIS_BITS-1:0] x_hi;
    logic [AXIS_BITS-1:0] y_lo;
    logic [AXIS_BITS-1:0] y_hi;
    logic [AXIS_BITS-1:0] z_lo;
    logic [AXIS_BITS-1:0] z_hi;
  } gwcp_in_t;

  // One chunk result.
  typedef struct packed {
    logic [AXIS_BITS-1:0] chunk_x_first;
    logic [AXIS_BITS-1:0] chunk_x_end;
    logic [AXIS_BITS-1:0] chunk_y_first;
    logic [AXIS_BITS-1:0] chunk_y_end;
    logic [AXIS_BITS-1:0] chunk_z_first;
    logic [AXIS_BITS-1:0] chunk_z_end;
    logic                 final_chunk;
  } gwcp_out_t;

endpackage

`default_nettype wire

// ===== hdl/grid_work_chunk_partitioner_top.sv =====
// Top level of the grid work chunk partitioner.
// Serial multiplier, chunk-size divider and coordinate divider with their control.
// Depends on gwcp_pkg.
//
// Usage:
//   The in_ channel takes one launch request (dimension count and a start and
//   exclusive end bound per axis). The block answers with one out_ item per
//   chunk of the linear range; the last one has final_chunk set. A launch with
//   zero dimensions or an empty grid gives no item. The cfg_ channel writes the
//   worker count; it is always ready and is meant to be written while idle.
//   The axis product is formed in a shift-add multiplier, the chunk size in
//   a radix-2 divider by 2*workers, then each chunk end is converted by
//   coordinate divisions (none in 1D, one in 2D, two in 3D) in a restoring
//   divider that yields one quotient bit per cycle. in_ready is high only
//   while no launch is in progress. A finished item waits in the output
//   register while the next chunk is computed; a stalled receiver holds the
//   block only at the point where the next item would be written. Reset
//   (rst_n low, synchronous) drops any launch and pending item and sets the
//   worker count to 4.
`default_nettype none

module grid_work_chunk_partitioner_top (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire gwcp_pkg::gwcp_in_t      in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output gwcp_pkg::gwcp_out_t          out_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [gwcp_pkg::WORKER_W-1:0] cfg_data
);

  import gwcp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL1 = 8'b0000_0010,
    S_MUL2 = 8'b0000_0100,
    S_CDIV = 8'b0000_1000,
    S_STEP = 8'b0001_0000,
    S_DIVA = 8'b0010_0000,
    S_DIVB = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  // Extent of one axis; a reversed axis counts as empty.
  function automatic logic [AXIS_BITS-1:0] span(input logic [AXIS_BITS-1:0] lo,
                                                input logic [AXIS_BITS-1:0] hi);
    span = (hi >= lo) ? (hi - lo) : '0;
  endfunction

  // Control registers.
  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WORKER_W-1:0] worker_r, worker_nxt;

  // Datapath registers.
  logic [DIM_W-1:0]     dims_r, dims_nxt;
  logic [AXIS_BITS-1:0] ex_r, ex_nxt;
  logic [AXIS_BITS-1:0] ez_r, ez_nxt;
  logic [PLANE_W-1:0]   plane_r, plane_nxt;
  logic [TOT_W-1:0]     total_r, total_nxt;
  logic [TOT_W-1:0]     acc_r, acc_nxt;
  logic [TOT_W-1:0]     mcand_r, mcand_nxt;
  logic [AXIS_BITS-1:0] mplier_r, mplier_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIV2_W-1:0]    crem_r, crem_nxt;
  logic [TOT_W-1:0]     chunk_r, chunk_nxt;
  logic [TOT_W-1:0]     pos_r, pos_nxt;
  logic [TOT_W-1:0]     end_r, end_nxt;
  logic                 last_r, last_nxt;
  logic [RES_W-1:0]     nres_r, nres_nxt;
  logic [TOT_W-1:0]     rem_r, rem_nxt;
  logic [TOT_W-1:0]     dsh_r, dsh_nxt;
  logic [AXIS_BITS-1:0] q_r, q_nxt;
  logic [AXIS_BITS-1:0] xs_r, xs_nxt, ys_r, ys_nxt, zs_r, zs_nxt;
  logic [AXIS_BITS-1:0] xe_r, xe_nxt, ye_r, ye_nxt, ze_r, ze_nxt;
  gwcp_out_t            out_r, out_nxt;

  // Combinational helpers.
  logic                 in_fire;
  logic [AXIS_BITS-1:0] in_ex, in_ey, in_ez;
  logic [TOT_W-1:0]     acc_sum;
  logic [DIV2_W:0]      ctrial;
  logic [DIV2_W:0]      cdivisor;
  logic                 cge;
  logic [TOT_W-1:0]     cq;
  logic                 dge;
  logic [TOT_W-1:0]     rem_step;
  logic [AXIS_BITS-1:0] q_step;
  logic [TOT_W-1:0]     rest;
  logic                 step_last;
  logic [TOT_W-1:0]     step_end;
  logic [WORKER_W-1:0]  w_clamp;
  logic                 mul_done, cdiv_done, div_done, emit_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_fire   = in_valid && in_ready;

  // Axis extents of the incoming launch; unused axes count as one.
  always_comb begin
    in_ex = span(in_data.x_lo, in_data.x_hi);
    in_ey = (in_data.dim_count >= DIM_2D) ? span(in_data.y_lo, in_data.y_hi)
                                          : AXIS_BITS'(1);
    in_ez = (in_data.dim_count == DIM_3D) ? span(in_data.z_lo, in_data.z_hi)
                                          : AXIS_BITS'(1);
  end

  // Clamped worker count and the chunk-size divisor of twice that.
  always_comb begin
    if (worker_r == '0) begin
      w_clamp = WORKER_W'(1);
    end else if (worker_r > WORKER_W'(MAX_WORKERS)) begin
      w_clamp = WORKER_W'(MAX_WORKERS);
    end else begin
      w_clamp = worker_r;
    end
    cdivisor = {(DIV2_W + 1 - WORKER_W)'(0), w_clamp} << 1;
  end

  // Shift-add multiplier step, radix-2 chunk divider step, restoring divider step.
  always_comb begin
    acc_sum  = acc_r + (mplier_r[0] ? mcand_r : '0);
    ctrial   = {crem_r, acc_r[TOT_W-1]};
    cge      = (ctrial >= cdivisor);
    cq       = {chunk_r[TOT_W-2:0], cge};
    dge      = (rem_r >= dsh_r);
    rem_step = dge ? (rem_r - dsh_r) : rem_r;
    q_step   = {q_r[AXIS_BITS-2:0], dge};
    mul_done  = (cnt_r == CNT_W'(AXIS_BITS - 1));
    div_done  = (cnt_r == CNT_W'(AXIS_BITS - 1));
    cdiv_done = (cnt_r == CNT_W'(TOT_W - 1));
  end

  // End of the current chunk, clipped to the total.
  always_comb begin
    rest      = total_r - pos_r;
    step_last = (chunk_r >= rest);
    step_end  = step_last ? total_r : (pos_r + chunk_r);
  end

  assign emit_ok = !out_valid_r || out_ready;

  // Next-state logic of the sequencer and its datapath.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    worker_nxt    = worker_r;
    dims_nxt      = dims_r;
    ex_nxt        = ex_r;
    ez_nxt        = ez_r;
    plane_nxt     = plane_r;
    total_nxt     = total_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    cnt_nxt       = cnt_r;
    crem_nxt      = crem_r;
    chunk_nxt     = chunk_r;
    pos_nxt       = pos_r;
    end_nxt       = end_r;
    last_nxt      = last_r;
    nres_nxt      = nres_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    q_nxt         = q_r;
    xs_nxt        = xs_r;
    ys_nxt        = ys_r;
    zs_nxt        = zs_r;
    xe_nxt        = xe_r;
    ye_nxt        = ye_r;
    ze_nxt        = ze_r;
    out_nxt       = out_r;

    if (cfg_valid && cfg_ready) begin
      worker_nxt = cfg_data;
    end

    // The receiver drains the output register.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          dims_nxt   = in_data.dim_count;
          ex_nxt     = in_ex;
          ez_nxt     = in_ez;
          acc_nxt    = '0;
          mcand_nxt  = TOT_W'(in_ex);
          mplier_nxt = in_ey;
          cnt_nxt    = '0;
          state_nxt  = (in_data.dim_count == DIM_NONE) ? S_IDLE : S_MUL1;
        end
      end

      // Plane size ex * ey.
      S_MUL1: begin
        acc_nxt    = acc_sum;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (mul_done) begin
          plane_nxt  = acc_sum[PLANE_W-1:0];
          acc_nxt    = '0;
          mcand_nxt  = acc_sum;
          mplier_nxt = ez_r;
          cnt_nxt    = '0;
          state_nxt  = S_MUL2;
        end
      end

      // Total size plane * ez.
      S_MUL2: begin
        acc_nxt    = acc_sum;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (mul_done) begin
          total_nxt = acc_sum;
          crem_nxt  = '0;
          chunk_nxt = '0;
          cnt_nxt   = '0;
          state_nxt = (acc_sum == '0) ? S_IDLE : S_CDIV;
        end
      end

      // Chunk size: total divided by twice the clamped worker count, at least one, one bit a cycle.
      S_CDIV: begin
        acc_nxt   = acc_r << 1;
        crem_nxt  = cge ? DIV2_W'(ctrial - cdivisor) : ctrial[DIV2_W-1:0];
        chunk_nxt = cq;
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cdiv_done) begin
          chunk_nxt = (cq == '0) ? TOT_W'(1) : cq;
          pos_nxt   = '0;
          nres_nxt  = '0;
          xs_nxt    = '0;
          ys_nxt    = '0;
          zs_nxt    = '0;
          state_nxt = S_STEP;
        end
      end

      // Next chunk end; start its coordinate conversion.
      S_STEP: begin
        end_nxt  = step_end;
        last_nxt = step_last || (nres_r == RES_W'(RESULT_LIMIT - 1));
        q_nxt    = '0;
        cnt_nxt  = '0;
        rem_nxt  = step_end;
        xe_nxt   = step_end[AXIS_BITS-1:0];
        ye_nxt   = '0;
        ze_nxt   = '0;
        case (dims_r)
          DIM_3D: begin
            dsh_nxt   = {{AXIS_BITS{1'b0}}, plane_r} << (AXIS_BITS - 1);
            state_nxt = S_DIVA;
          end
          DIM_2D: begin
            dsh_nxt   = {{PLANE_W{1'b0}}, ex_r} << (AXIS_BITS - 1);
            state_nxt = S_DIVB;
          end
          default: begin
            state_nxt = S_EMIT;
          end
        endcase
      end

      // z = end / plane; the remainder goes on to the y and x division.
      S_DIVA: begin
        rem_nxt = rem_step;
        q_nxt   = q_step;
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (div_done) begin
          ze_nxt    = q_step;
          q_nxt     = '0;
          cnt_nxt   = '0;
          dsh_nxt   = {{PLANE_W{1'b0}}, ex_r} << (AXIS_BITS - 1);
          state_nxt = S_DIVB;
        end
      end

      // y = value / ex, x = value % ex.
      S_DIVB: begin
        rem_nxt = rem_step;
        q_nxt   = q_step;
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (div_done) begin
          ye_nxt    = q_step;
          xe_nxt    = rem_step[AXIS_BITS-1:0];
          state_nxt = S_EMIT;
        end
      end

      // Write the item once the output register is free.
      S_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt         = 1'b1;
          out_nxt.chunk_x_first = xs_r;
          out_nxt.chunk_x_end   = xe_r;
          out_nxt.chunk_y_first = ys_r;
          out_nxt.chunk_y_end   = ye_r;
          out_nxt.chunk_z_first = zs_r;
          out_nxt.chunk_z_end   = ze_r;
          out_nxt.final_chunk   = last_r;
          xs_nxt    = xe_r;
          ys_nxt    = ye_r;
          zs_nxt    = ze_r;
          pos_nxt   = end_r;
          nres_nxt  = nres_r + RES_W'(1);
          state_nxt = last_r ? S_IDLE : S_STEP;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      worker_r    <= WORKER_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      worker_r    <= worker_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    dims_r   <= dims_nxt;
    ex_r     <= ex_nxt;
    ez_r     <= ez_nxt;
    plane_r  <= plane_nxt;
    total_r  <= total_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    cnt_r    <= cnt_nxt;
    crem_r   <= crem_nxt;
    chunk_r  <= chunk_nxt;
    pos_r    <= pos_nxt;
    end_r    <= end_nxt;
    last_r   <= last_nxt;
    nres_r   <= nres_nxt;
    rem_r    <= rem_nxt;
    dsh_r    <= dsh_nxt;
    q_r      <= q_nxt;
    xs_r     <= xs_nxt;
    ys_r     <= ys_nxt;
    zs_r     <= zs_nxt;
    xe_r     <= xe_nxt;
    ye_r     <= ye_nxt;
    ze_r     <= ze_nxt;
    out_r    <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/gwcp_checker.sv =====
// Port-level checker for the grid work chunk partitioner, with its bind.
// Watches the top level's channels over time.
// Depends on gwcp_pkg and grid_work_chunk_partitioner_top.
`default_nettype none

module gwcp_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_valid,
  input wire                      in_ready,
  input wire gwcp_pkg::gwcp_in_t  in_data,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire gwcp_pkg::gwcp_out_t out_data
);

  import gwcp_pkg::*;

  // A stalled item holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  // Reset leaves no item pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("item pending right after reset");

  // A taken launch with dimensions keeps the block busy for at least the next cycle.
  a_busy_after_launch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.dim_count != DIM_NONE) |=> !in_ready)
    else $error("block ready again right after taking a launch");

  // While a non-final chunk waits, its launch is still in progress.
  a_busy_mid_launch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.final_chunk |-> !in_ready)
    else $error("new launch accepted before the final chunk");

endmodule

bind grid_work_chunk_partitioner_top gwcp_checker u_gwcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
